@@ hdl/acpu_pkg.sv @@
// Package for the accumulator machine execute unit: opcodes, sizes, sequencer types.
`default_nettype none
package acpu_pkg;

	localparam int WORD_W   = 8;
	localparam int RAM_DEPTH = 256;
	localparam int ROWS     = 16;
	localparam int COLS     = 16;
	localparam int ROW_W    = $clog2(ROWS);
	localparam int COL_W    = $clog2(COLS);

	localparam logic [WORD_W-1:0] INDIRECT_SEL = 8'd255;

	localparam logic [7:0] OP_ADD   = 8'd1;
	localparam logic [7:0] OP_SUB   = 8'd2;
	localparam logic [7:0] OP_JMP   = 8'd3;
	localparam logic [7:0] OP_JNZ   = 8'd4;
	localparam logic [7:0] OP_JNE   = 8'd5;
	localparam logic [7:0] OP_LDI   = 8'd6;
	localparam logic [7:0] OP_LOAD  = 8'd7;
	localparam logic [7:0] OP_STORE = 8'd8;
	localparam logic [7:0] OP_PRINT = 8'd9;
	localparam logic [7:0] OP_LDB   = 8'd10;
	localparam logic [7:0] OP_MOVB  = 8'd11;
	localparam logic [7:0] OP_PIXEL = 8'd12;
	localparam logic [7:0] OP_DUMP  = 8'd13;
	localparam logic [7:0] OP_CLEAR = 8'd14;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD,
		S_PIX,
		S_PC,
		S_EMIT,
		S_DUMP_RD,
		S_DUMP_EMIT
	} acpu_state_t;

	// Strobes that the sequencer hands to the datapath and the memories.
	typedef struct packed {
		logic dram_re;
		logic dram_we;
		logic scr_re;
		logic scr_we;
		logic push;
	} acpu_ctl_t;

endpackage
`default_nettype wire

@@ hdl/acpu_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module acpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/accumulator_cpu_execute.sv @@
// Top level of the accumulator machine execute unit: sequencer, shared ALU and state.
//
//   channel  direction  handshake                  payload
//   instr    in         instr_valid / instr_stall  cmd, operand
//   result   out        result_valid / result_stall next_pc, print_valid, print_value,
//                                                   row_valid, row_bits, last
//
// Flow: an instruction is taken in the idle state and the unit stalls its input until
// its last beat is in the output register. Every instruction has an execute and a PC
// step; loads and pixel writes add a registered RAM read step, and a dump then
// reads and emits each row. The single shared adder serves A +/- B and then PC + 1.
// Reset clears state registers and valid bits of data RAM and screen rows; no sweep.
// A stalled result holds in the output register and the sequencer waits to push behind it.
`default_nettype none
module accumulator_cpu_execute
	import acpu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        instr_valid,
	output logic             instr_stall,
	input  wire logic [7:0]  cmd,
	input  wire logic [7:0]  operand,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       next_pc,
	output logic             print_valid,
	output logic [7:0]       print_value,
	output logic             row_valid,
	output logic [15:0]      row_bits,
	output logic             last
);

	localparam int DAW = $clog2(RAM_DEPTH);

	acpu_state_t state_q, state_nxt;
	acpu_ctl_t   ctl;

	// Architectural state.
	logic [WORD_W-1:0] acc_q, breg_q, pc_q;
	logic              flag_q;
	// Each data RAM word and each screen row reads as zero until it has been written.
	logic [RAM_DEPTH-1:0] dvalid_q;
	logic [ROWS-1:0]      srv_q;

	// Instruction being worked on.
	logic [7:0]       cmd_q, opr_q;
	logic [DAW-1:0]   daddr_q;
	logic [ROW_W-1:0] row_q;

	logic accept;
	logic can_push;
	assign accept   = instr_valid && !instr_stall;
	assign can_push = !result_valid || !result_stall;
	assign instr_stall = (state_q != S_IDLE);

	// The one adder of the unit. In the execute step it forms A + B or A - B, and its
	// zero test gives the not-equal flag; in the PC step it forms PC + 1.
	logic [WORD_W-1:0] alu_a, alu_b, alu_y;
	logic              alu_sub;
	always_comb begin
		if (state_q == S_PC) begin
			alu_a   = pc_q;
			alu_b   = WORD_W'(1);
			alu_sub = 1'b0;
		end else begin
			alu_a   = acc_q;
			alu_b   = breg_q;
			alu_sub = (cmd_q == OP_SUB);
		end
		alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	end

	logic [DAW-1:0] daddr;
	assign daddr = (opr_q != INDIRECT_SEL) ? opr_q : breg_q;

	logic jumped;
	assign jumped = (cmd_q == OP_JMP) || ((cmd_q == OP_JNZ) && (acc_q != '0)) ||
		((cmd_q == OP_JNE) && flag_q);

	// Memories.
	logic [WORD_W-1:0] dram_rdata;
	acpu_ram #(.WIDTH(WORD_W), .DEPTH(RAM_DEPTH)) u_dram (
		.clk   (clk),
		.we    (ctl.dram_we),
		.waddr (daddr),
		.wdata (acc_q),
		.re    (ctl.dram_re),
		.raddr (daddr),
		.rdata (dram_rdata)
	);

	logic [ROW_W-1:0] scr_raddr;
	logic [COLS-1:0]  scr_rdata, pix_row, row_old;
	assign scr_raddr = (state_q == S_EXEC) ? acc_q[WORD_W-1 -: ROW_W] : row_q;
	assign row_old   = srv_q[acc_q[WORD_W-1 -: ROW_W]] ? scr_rdata : '0;

	always_comb begin
		pix_row = row_old;
		pix_row[acc_q[COL_W-1:0]] = (opr_q != '0);
	end

	acpu_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_screen (
		.clk   (clk),
		.we    (ctl.scr_we),
		.waddr (acc_q[WORD_W-1 -: ROW_W]),
		.wdata (pix_row),
		.re    (ctl.scr_re),
		.raddr (scr_raddr),
		.rdata (scr_rdata)
	);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				priority if (cmd_q == OP_LOAD) state_nxt = S_LOAD;
				else if (cmd_q == OP_PIXEL) state_nxt = S_PIX;
				else state_nxt = S_PC;
			end
			S_LOAD:  state_nxt = S_PC;
			S_PIX:   state_nxt = S_PC;
			S_PC:    state_nxt = (cmd_q == OP_DUMP) ? S_DUMP_RD : S_EMIT;
			S_EMIT: begin
				if (can_push) state_nxt = S_IDLE;
			end
			S_DUMP_RD: state_nxt = S_DUMP_EMIT;
			S_DUMP_EMIT: begin
				if (can_push) state_nxt = (row_q == '0) ? S_IDLE : S_DUMP_RD;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Sequencer strobes.
	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_EXEC: begin
				ctl.dram_re = (cmd_q == OP_LOAD);
				ctl.dram_we = (cmd_q == OP_STORE);
				ctl.scr_re  = (cmd_q == OP_PIXEL);
			end
			S_PIX:       ctl.scr_we = 1'b1;
			S_EMIT:      ctl.push   = can_push;
			S_DUMP_RD:   ctl.scr_re = 1'b1;
			S_DUMP_EMIT: ctl.push   = can_push;
			default: ;
		endcase
	end

	// Control and architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			acc_q    <= '0;
			breg_q   <= '0;
			flag_q   <= 1'b0;
			pc_q     <= '0;
			dvalid_q <= '0;
			srv_q    <= '0;
			row_q    <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				S_IDLE: begin
					row_q <= ROW_W'(ROWS - 1);
				end
				S_EXEC: begin
					unique case (cmd_q)
						OP_ADD:   acc_q <= alu_y;
						OP_SUB: begin
							acc_q  <= alu_y;
							flag_q <= (alu_y != '0);
						end
						OP_LDI:   acc_q  <= opr_q;
						OP_STORE: dvalid_q[daddr] <= 1'b1;
						OP_LDB:   breg_q <= opr_q;
						OP_MOVB:  breg_q <= acc_q;
						OP_CLEAR: srv_q  <= '0;
						default: ;
					endcase
				end
				S_LOAD: acc_q <= dvalid_q[daddr_q] ? dram_rdata : '0;
				S_PIX:  srv_q[acc_q[WORD_W-1 -: ROW_W]] <= 1'b1;
				S_PC:   pc_q <= jumped ? opr_q : alu_y;
				S_DUMP_EMIT: begin
					if (can_push) row_q <= row_q - ROW_W'(1);
				end
				default: ;
			endcase
			if (ctl.push) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			opr_q <= operand;
		end
		if (state_q == S_EXEC) begin
			daddr_q <= daddr;
		end
		if (ctl.push) begin
			next_pc <= pc_q;
			if (state_q == S_DUMP_EMIT) begin
				print_valid <= 1'b0;
				print_value <= '0;
				row_valid   <= 1'b1;
				row_bits    <= srv_q[row_q] ? scr_rdata : '0;
				last        <= (row_q == '0);
			end else begin
				print_valid <= (cmd_q == OP_PRINT);
				print_value <= (cmd_q == OP_PRINT) ? acc_q : '0;
				row_valid   <= 1'b0;
				row_bits    <= '0;
				last        <= 1'b1;
			end
		end
	end

	// A beat is only pushed into a free or draining output register.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> (!result_valid || !result_stall))
		else $error("result register overwritten while stalled");

	// An accepted instruction closes the input until it is done.
	a_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> instr_stall)
		else $error("input reopened right after accept");

	// A dump row that is not the last one is followed by more rows.
	a_dump_more: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push && state_q == S_DUMP_EMIT && row_q != '0) |=> (state_q == S_DUMP_RD))
		else $error("dump ended early");

	// A beat never carries both a print and a row.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(print_valid && row_valid))
		else $error("print and row in one beat");

endmodule
`default_nettype wire
